// ----- hdl/lppe_pkg.sv -----
// ----------------------------------------------------------------------------
// lppe_pkg
// Shared constants and controller/datapath interface types for the LED pixel
// pulse encoder.
// ----------------------------------------------------------------------------
package lppe_pkg;

    localparam int PIXEL_BITS  = 24;
    localparam int WORD_BITS   = 32;
    localparam int EXT_BITS    = 2 * WORD_BITS;

    localparam int FILL_W      = $clog2(WORD_BITS);
    localparam int SUM_W       = FILL_W + 1;
    localparam int SHIFT_W     = $clog2(EXT_BITS) + 1;
    localparam int BIT_IDX_W   = $clog2(PIXEL_BITS);
    localparam int LEN_W       = 5;
    localparam int RSTW_W      = 6;

    localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((WORD_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_WORDS = 2'd2;

    localparam logic [LEN_W-1:0]  LONG_BITS_RST   = 5'd9;
    localparam logic [LEN_W-1:0]  SHORT_BITS_RST  = 5'd4;
    localparam logic [RSTW_W-1:0] RESET_WORDS_RST = 6'd32;

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_RESET = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEG,
        OP_FLUSH,
        OP_ZERO,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
        logic   phase;   // 0: first part of the pulse, 1: second part
    } dp_cmd_t;

    typedef struct packed {
        logic step_ok;
        logic filled_nz;
    } dp_stat_t;

endpackage

// ----- hdl/led_pixel_pulse_encoder_core.sv -----
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder_core
// Turns pixel words into packed serial pulse slots, with reset/flush requests.
//
//   channel  dir  handshake                payload
//   s_*      in   s_tvalid / s_tready      tdata: pixel; tuser: action
//   m_*      out  m_tvalid / m_tready      tdata: word; tlast: last
//   cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A pixel request steps through accept, one pulse part per cycle in the single
// slot packer while the output does not stall it, and a tlast step.
// A reset request steps through accept, flush or skip, one step per zero word,
// end check and tlast step, plus any output stall.
// Each word is held one step so the last word of a request can carry tlast.
// A stalled m_tready stalls the packer only when a new word must move out.
// rst_n clears the pending word and loads the timing register defaults.
// ----------------------------------------------------------------------------
module led_pixel_pulse_encoder_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lppe_pkg::IN_TDATA_W-1:0]    s_tdata,   // [23:0] pixel
    input  logic                               s_tuser,   // [0] action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lppe_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [31:0] word
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lppe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lppe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [lppe_pkg::LEN_W-1:0]  long_bits;
    logic [lppe_pkg::LEN_W-1:0]  short_bits;
    logic [lppe_pkg::RSTW_W-1:0] reset_words;
    lppe_pkg::dp_cmd_t           cmd;
    lppe_pkg::dp_stat_t          stat;

    lppe_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .long_bits   (long_bits),
        .short_bits  (short_bits),
        .reset_words (reset_words)
    );

    lppe_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .reset_words (reset_words),
        .stat        (stat),
        .cmd         (cmd)
    );

    lppe_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .pixel_in    (s_tdata[lppe_pkg::PIXEL_BITS-1:0]),
        .long_bits   (long_bits),
        .short_bits  (short_bits),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_word    (m_tdata[lppe_pkg::WORD_BITS-1:0]),
        .out_last    (m_tlast)
    );

endmodule

// ----- hdl/lppe_cfg.sv -----
// ----------------------------------------------------------------------------
// lppe_cfg
// Timing register file: pulse part lengths and reset word count.
// ----------------------------------------------------------------------------
module lppe_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lppe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lppe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [lppe_pkg::LEN_W-1:0]       long_bits,
    output logic [lppe_pkg::LEN_W-1:0]       short_bits,
    output logic [lppe_pkg::RSTW_W-1:0]      reset_words
);

    logic [lppe_pkg::LEN_W-1:0]  long_bits_reg;
    logic [lppe_pkg::LEN_W-1:0]  short_bits_reg;
    logic [lppe_pkg::RSTW_W-1:0] reset_words_reg;

    assign cfg_ready   = 1'b1;
    assign long_bits   = long_bits_reg;
    assign short_bits  = short_bits_reg;
    assign reset_words = reset_words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_bits_reg   <= lppe_pkg::LONG_BITS_RST;
            short_bits_reg  <= lppe_pkg::SHORT_BITS_RST;
            reset_words_reg <= lppe_pkg::RESET_WORDS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lppe_pkg::REG_LONG_BITS:
                    long_bits_reg <= cfg_data[lppe_pkg::LEN_W-1:0];
                lppe_pkg::REG_SHORT_BITS:
                    short_bits_reg <= cfg_data[lppe_pkg::LEN_W-1:0];
                lppe_pkg::REG_RESET_WORDS:
                    reset_words_reg <= cfg_data[lppe_pkg::RSTW_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

// ----- hdl/lppe_dp.sv -----
// ----------------------------------------------------------------------------
// lppe_dp
// Slot packer: pending word, one-word hold for end-of-item marking, and the
// output register.
// ----------------------------------------------------------------------------
module lppe_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  lppe_pkg::dp_cmd_t                  cmd,
    output lppe_pkg::dp_stat_t                 stat,
    input  logic [lppe_pkg::PIXEL_BITS-1:0]    pixel_in,
    input  logic [lppe_pkg::LEN_W-1:0]         long_bits,
    input  logic [lppe_pkg::LEN_W-1:0]         short_bits,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lppe_pkg::WORD_BITS-1:0]     out_word,
    output logic                               out_last
);

    localparam int WB = lppe_pkg::WORD_BITS;
    localparam int EB = lppe_pkg::EXT_BITS;

    logic [lppe_pkg::PIXEL_BITS-1:0] pix_reg,      pix_next;
    logic [WB-1:0]                   pending_reg,  pending_next;
    logic [lppe_pkg::FILL_W-1:0]     filled_reg,   filled_next;
    logic [WB-1:0]                   hold_reg,     hold_next;
    logic                            hold_v_reg,   hold_v_next;
    logic [WB-1:0]                   out_word_reg, out_word_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_v_reg,    out_v_next;

    logic                            cur_bit;
    logic                            seg_level;
    logic [lppe_pkg::LEN_W-1:0]      seg_cnt;
    logic [lppe_pkg::SUM_W-1:0]      sum;
    logic                            completes;
    logic [EB-1:0]                   ones;
    logic [lppe_pkg::SHIFT_W-1:0]    sh;
    logic [EB-1:0]                   ext;
    logic                            out_free;
    logic                            step_ok;
    logic                            produce;
    logic [WB-1:0]                   new_word;

    // first part of every pulse is high, second part low
    assign cur_bit   = pix_reg[lppe_pkg::PIXEL_BITS-1];
    assign seg_level = ~cmd.phase;
    assign seg_cnt   = (cur_bit ^ cmd.phase) ? long_bits : short_bits;
    assign sum       = lppe_pkg::SUM_W'(filled_reg) + lppe_pkg::SUM_W'(seg_cnt);
    assign completes = (sum >= lppe_pkg::SUM_W'(WB));

    // run of seg_cnt ones placed right after the filled slots
    assign ones = ~({EB{1'b1}} << seg_cnt);
    assign sh   = lppe_pkg::SHIFT_W'(EB) - lppe_pkg::SHIFT_W'(filled_reg)
                  - lppe_pkg::SHIFT_W'(seg_cnt);
    assign ext  = {pending_reg, {WB{1'b0}}} | (seg_level ? (ones << sh) : {EB{1'b0}});

    assign out_free = !out_v_reg || out_ready;

    always_comb
    begin
        pix_next      = pix_reg;
        pending_next  = pending_reg;
        filled_next   = filled_reg;
        hold_next     = hold_reg;
        hold_v_next   = hold_v_reg;
        out_word_next = out_word_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !out_ready;
        step_ok       = 1'b0;
        produce       = 1'b0;
        new_word      = '0;

        if (cmd.load)
            pix_next = pixel_in;

        unique case (cmd.op)
            lppe_pkg::OP_SEG:
            begin
                step_ok = !completes || !hold_v_reg || out_free;
                if (step_ok)
                begin
                    if (completes)
                    begin
                        produce      = 1'b1;
                        new_word     = ext[EB-1:WB];
                        pending_next = ext[WB-1:0];
                        filled_next  = lppe_pkg::FILL_W'(sum - lppe_pkg::SUM_W'(WB));
                    end
                    else
                    begin
                        pending_next = ext[EB-1:WB];
                        filled_next  = sum[lppe_pkg::FILL_W-1:0];
                    end
                    if (cmd.phase)
                        pix_next = {pix_reg[lppe_pkg::PIXEL_BITS-2:0], 1'b0};
                end
            end
            lppe_pkg::OP_FLUSH:
            begin
                step_ok = !hold_v_reg || out_free;
                if (step_ok)
                begin
                    produce      = 1'b1;
                    new_word     = pending_reg;
                    pending_next = '0;
                    filled_next  = '0;
                end
            end
            lppe_pkg::OP_ZERO:
            begin
                step_ok = !hold_v_reg || out_free;
                produce = step_ok;
            end
            lppe_pkg::OP_FINAL:
            begin
                step_ok = !hold_v_reg || out_free;
                if (hold_v_reg && out_free)
                begin
                    out_word_next = hold_reg;
                    out_last_next = 1'b1;
                    out_v_next    = 1'b1;
                    hold_v_next   = 1'b0;
                end
            end
            lppe_pkg::OP_NONE:
                ;
            default:
                ;
        endcase

        // the held word goes out unmarked once a later word exists
        if (produce)
        begin
            if (hold_v_reg)
            begin
                out_word_next = hold_reg;
                out_last_next = 1'b0;
                out_v_next    = 1'b1;
            end
            hold_next   = new_word;
            hold_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            filled_reg  <= '0;
            hold_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            filled_reg  <= filled_next;
            hold_v_reg  <= hold_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        hold_reg     <= hold_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign stat.step_ok   = step_ok;
    assign stat.filled_nz = (filled_reg != '0);
    assign out_valid      = out_v_reg;
    assign out_word       = out_word_reg;
    assign out_last       = out_last_reg;

endmodule

// ----- hdl/lppe_ctrl.sv -----
// ----------------------------------------------------------------------------
// lppe_ctrl
// Sequencer: walks pixel bits and pulse parts, or flush and reset words,
// one datapath step per cycle unless an output stall holds the step.
// ----------------------------------------------------------------------------
module lppe_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_action,
    input  logic [lppe_pkg::RSTW_W-1:0]     reset_words,
    input  lppe_pkg::dp_stat_t              stat,
    output lppe_pkg::dp_cmd_t               cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIX,
        S_FLUSH,
        S_ZERO,
        S_LAST
    } state_t;

    state_t                            state_reg, state_next;
    logic [lppe_pkg::BIT_IDX_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic                              phase_reg, phase_next;
    logic [lppe_pkg::RSTW_W-1:0]       zero_cnt_reg, zero_cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        phase_next    = phase_reg;
        zero_cnt_next = zero_cnt_reg;
        cmd.load      = 1'b0;
        cmd.op        = lppe_pkg::OP_NONE;
        cmd.phase     = phase_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_action == lppe_pkg::ACTION_RESET)
                    begin
                        zero_cnt_next = reset_words;
                        state_next    = S_FLUSH;
                    end
                    else
                    begin
                        bit_cnt_next = lppe_pkg::BIT_IDX_W'(lppe_pkg::PIXEL_BITS - 1);
                        phase_next   = 1'b0;
                        state_next   = S_PIX;
                    end
                end
            end
            S_PIX:
            begin
                cmd.op = lppe_pkg::OP_SEG;
                if (stat.step_ok)
                begin
                    phase_next = ~phase_reg;
                    if (phase_reg)
                    begin
                        bit_cnt_next = bit_cnt_reg - 1'b1;
                        if (bit_cnt_reg == '0)
                            state_next = S_LAST;
                    end
                end
            end
            S_FLUSH:
            begin
                if (stat.filled_nz)
                begin
                    cmd.op = lppe_pkg::OP_FLUSH;
                    if (stat.step_ok)
                        state_next = S_ZERO;
                end
                else
                    state_next = S_ZERO;
            end
            S_ZERO:
            begin
                if (zero_cnt_reg == '0)
                    state_next = S_LAST;
                else
                begin
                    cmd.op = lppe_pkg::OP_ZERO;
                    if (stat.step_ok)
                        zero_cnt_next = zero_cnt_reg - 1'b1;
                end
            end
            S_LAST:
            begin
                cmd.op = lppe_pkg::OP_FINAL;
                if (stat.step_ok)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bit_cnt_reg  <= '0;
            phase_reg    <= 1'b0;
            zero_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            phase_reg    <= phase_next;
            zero_cnt_reg <= zero_cnt_next;
        end
    end

endmodule

// ----- test/lppe_pulse_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lppe_pulse_checker
// Watches the pixel, word and register channels of the pulse encoder. Keeps
// its own copy of the timing registers and the partial word, builds the
// expected output words for every accepted request and compares each
// accepted word (data and tlast) with the oldest one still owed.
// ----------------------------------------------------------------------------
module lppe_pulse_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [lppe_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [lppe_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [lppe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lppe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                outstanding,
    output int                                words_checked,
    output int                                requests_seen,
    output int                                resets_seen
);

    typedef struct packed {
        logic [lppe_pkg::WORD_BITS-1:0] word;
        logic                           last;
    } pulse_word_t;

    pulse_word_t                    expected_words[$];
    logic [lppe_pkg::LEN_W-1:0]     long_len;
    logic [lppe_pkg::LEN_W-1:0]     short_len;
    logic [lppe_pkg::RSTW_W-1:0]    zero_words;
    logic [lppe_pkg::WORD_BITS-1:0] acc_word;
    int                             acc_fill;

    task automatic note_mismatch(input string what,
                                 input logic [lppe_pkg::WORD_BITS-1:0] exp_v,
                                 input logic [lppe_pkg::WORD_BITS-1:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
    endtask

    // slots go in MSB first; a full word is owed at once
    task automatic place_slots(input int count, input logic level);
        for (int k = 0; k < count; k++)
        begin
            if (level)
                acc_word[lppe_pkg::WORD_BITS-1-acc_fill] = 1'b1;
            acc_fill++;
            if (acc_fill == lppe_pkg::WORD_BITS)
            begin
                expected_words.push_back('{word: acc_word, last: 1'b0});
                acc_word = '0;
                acc_fill = 0;
            end
        end
    endtask

    task automatic predict_request(input logic act,
                                   input logic [lppe_pkg::PIXEL_BITS-1:0] pix);
        int base;
        base = expected_words.size();
        requests_seen++;
        if (act == lppe_pkg::ACTION_RESET)
        begin
            resets_seen++;
            if (acc_fill != 0)
            begin
                expected_words.push_back('{word: acc_word, last: 1'b0});
                acc_word = '0;
                acc_fill = 0;
            end
            repeat (zero_words)
                expected_words.push_back('{word: '0, last: 1'b0});
        end
        else
        begin
            for (int b = lppe_pkg::PIXEL_BITS - 1; b >= 0; b--)
            begin
                if (pix[b])
                begin
                    place_slots(int'(long_len), 1'b1);
                    place_slots(int'(short_len), 1'b0);
                end
                else
                begin
                    place_slots(int'(short_len), 1'b1);
                    place_slots(int'(long_len), 1'b0);
                end
            end
        end
        if (expected_words.size() > base)
            expected_words[expected_words.size()-1].last = 1'b1;
    endtask

    task automatic check_word(input logic [lppe_pkg::WORD_BITS-1:0] word, input logic last);
        pulse_word_t want;
        words_checked++;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected word %h (tlast %b), none owed", $time, word, last);
        end
        else
        begin
            want = expected_words.pop_front();
            if (word !== want.word)
                note_mismatch("word", want.word, word);
            if (last !== want.last)
                note_mismatch("tlast", lppe_pkg::WORD_BITS'(want.last),
                              lppe_pkg::WORD_BITS'(last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_len   = lppe_pkg::LONG_BITS_RST;
            short_len  = lppe_pkg::SHORT_BITS_RST;
            zero_words = lppe_pkg::RESET_WORDS_RST;
            acc_word   = '0;
            acc_fill   = 0;
            expected_words.delete();
            outstanding   = 0;
            mismatches    = 0;
            words_checked = 0;
            requests_seen = 0;
            resets_seen   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lppe_pkg::REG_LONG_BITS:
                        long_len = cfg_data[lppe_pkg::LEN_W-1:0];
                    lppe_pkg::REG_SHORT_BITS:
                        short_len = cfg_data[lppe_pkg::LEN_W-1:0];
                    lppe_pkg::REG_RESET_WORDS:
                        zero_words = cfg_data[lppe_pkg::RSTW_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[lppe_pkg::PIXEL_BITS-1:0]);
            if (m_tvalid && m_tready)
                check_word(m_tdata[lppe_pkg::WORD_BITS-1:0], m_tlast);
            outstanding = expected_words.size();
        end
    end

endmodule

// ----- test/tb_led_pixel_pulse_encoder_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_pixel_pulse_encoder_core
// Drives pixel and reset requests and timing register writes into the pulse
// encoder, with random stalls on both streams. A directed pass covers the
// corner patterns and register extremes, then random frames run under a
// series of timing settings. The checker beside the core does the scoring.
// ----------------------------------------------------------------------------
module tb_led_pixel_pulse_encoder_core;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 64;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [lppe_pkg::IN_TDATA_W-1:0]   s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [lppe_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                              m_tlast;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [lppe_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [lppe_pkg::CFG_DATA_W-1:0]   cfg_data;

    int mismatches;
    int outstanding;
    int words_checked;
    int requests_seen;
    int resets_seen;
    int src_idle;
    int dst_idle;
    int settings_used;

    led_pixel_pulse_encoder_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lppe_pulse_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .requests_seen (requests_seen),
        .resets_seen   (resets_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= dst_idle);

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d words still owed", CYCLE_LIMIT, outstanding);
        $display("Simulation FAILED");
        $finish;
    end

    // s_tvalid is left high after acceptance; gaps, drain and the end lower it
    task automatic send_request(input logic act,
                                input logic [lppe_pkg::PIXEL_BITS-1:0] pix);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= lppe_pkg::IN_TDATA_W'(pix);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lppe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lppe_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input int long_v, input int short_v, input int zeros_v);
        write_reg(lppe_pkg::REG_LONG_BITS, lppe_pkg::CFG_DATA_W'(long_v));
        write_reg(lppe_pkg::REG_SHORT_BITS, lppe_pkg::CFG_DATA_W'(short_v));
        write_reg(lppe_pkg::REG_RESET_WORDS, lppe_pkg::CFG_DATA_W'(zeros_v));
        settings_used++;
    endtask

    function automatic logic [lppe_pkg::PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return lppe_pkg::PIXEL_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        int sent;
        int npix;
        bit paused;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= lppe_pkg::ACTION_PIXEL;
        cfg_valid <= 1'b0;
        cfg_index <= lppe_pkg::REG_LONG_BITS;
        cfg_data  <= '0;
        src_idle = 26;
        dst_idle = 47;
        settings_used = 1;
        paused = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: reset on empty word, corner pixels, flush of a partial word
        send_request(lppe_pkg::ACTION_RESET, lppe_pkg::PIXEL_BITS'($urandom));
        send_request(lppe_pkg::ACTION_PIXEL, 24'h000000);
        send_request(lppe_pkg::ACTION_PIXEL, 24'hFFFFFF);
        send_request(lppe_pkg::ACTION_PIXEL, 24'h800000);
        send_request(lppe_pkg::ACTION_PIXEL, 24'h000001);
        send_request(lppe_pkg::ACTION_RESET, 24'hFFFFFF);
        send_request(lppe_pkg::ACTION_RESET, 24'h000000);
        send_request(lppe_pkg::ACTION_PIXEL, 24'hAAAAAA);
        send_request(lppe_pkg::ACTION_PIXEL, 24'h555555);
        drain();

        // longest pulses, no reset zeros: an empty reset gives nothing
        set_timing(31, 31, 0);
        send_request(lppe_pkg::ACTION_RESET, lppe_pkg::PIXEL_BITS'($urandom));
        send_request(lppe_pkg::ACTION_RESET, lppe_pkg::PIXEL_BITS'($urandom));
        send_request(lppe_pkg::ACTION_PIXEL, 24'hFFFFFF);
        send_request(lppe_pkg::ACTION_PIXEL, 24'h000000);
        send_request(lppe_pkg::ACTION_RESET, 24'h000000);
        drain();

        // both lengths zero: a pixel adds no slots
        set_timing(0, 0, 1);
        send_request(lppe_pkg::ACTION_PIXEL, lppe_pkg::PIXEL_BITS'($urandom));
        send_request(lppe_pkg::ACTION_RESET, 24'h000000);
        drain();

        // zero short part, then a flush with the most zero words
        set_timing(1, 0, 63);
        send_request(lppe_pkg::ACTION_PIXEL, 24'hFFFFFF);
        send_request(lppe_pkg::ACTION_PIXEL, 24'h000000);
        send_request(lppe_pkg::ACTION_RESET, lppe_pkg::PIXEL_BITS'($urandom));

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            case (seg)
                0: set_timing(31, 31, 63);
                1: set_timing(1, 1, 0);
                2: set_timing(0, 7, 5);
                3: set_timing(12, 0, 1);
                4: set_timing(1, 31, 63);
                5: set_timing(31, 1, 2);
                default: set_timing($urandom_range(1, 31), $urandom_range(1, 31),
                                    $urandom_range(0, 63));
            endcase
            if (seg < 3)
            begin
                src_idle = 26;
                dst_idle = 47;
            end
            else if (seg < 6)
            begin
                src_idle = 47;
                dst_idle = 26;
            end
            else
            begin
                src_idle = 0;
                dst_idle = 0;
            end

            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                if (seg == 4 && !paused && sent >= SEG_ITEMS / 2)
                begin
                    drain();
                    paused = 1;
                end
                if ($urandom_range(0, 9) < 8)
                begin
                    // one frame: reset, a few pixels, reset
                    npix = $urandom_range(1, 6);
                    send_request(lppe_pkg::ACTION_RESET, lppe_pkg::PIXEL_BITS'($urandom));
                    for (int p = 0; p < npix; p++)
                        send_request(lppe_pkg::ACTION_PIXEL, pick_pixel());
                    send_request(lppe_pkg::ACTION_RESET, lppe_pkg::PIXEL_BITS'($urandom));
                    sent += npix + 2;
                end
                else
                begin
                    send_request($urandom_range(0, 1) ? lppe_pkg::ACTION_RESET
                                                      : lppe_pkg::ACTION_PIXEL,
                                 pick_pixel());
                    sent++;
                end
            end
        end

        drain();
        $display("Covered %0d requests (%0d resets) under %0d timing settings,",
                 requests_seen, resets_seen, settings_used);
        $display("with stalls on both streams; %0d words checked, %0d mismatches.",
                 words_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
